@@ src/arat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package arat_pkg;

  localparam int unsigned MaxRegionsDef = 64;
  localparam int unsigned PageShift     = 12;

  localparam logic [31:0] SearchBaseRst = 32'h3000_0000;
  localparam logic [33:0] GapLimit      = 34'h0_C000_0000;
  localparam logic [32:0] TopAddr       = 33'h1_0000_0000;
  localparam logic [32:0] PageMask      = 33'h0_0000_0FFF;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_GAP    = 2'd2;
  localparam logic [1:0] REQ_UNMAP  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_OVERLAP  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [19:0] start_page;
    logic [20:0] end_page;
    logic [31:0] flags;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_start;
    logic [32:0] found_end;
    logic [31:0] found_flags;
  } result_t;

endpackage
`default_nettype wire

@@ src/address_region_table.sv @@
// Address region table: a sorted table of up to MAX_REGIONS non-overlapping,
// page-aligned regions (4 KiB pages), each with a start, an exclusive end and
// 32 flag bits, held in one single-port-read synchronous memory. Four requests
// are served one at a time: insert, lookup of the region holding an address,
// first-fit gap search from search_base up to 0xC0000000, and unmap (remove,
// trim or split). Every result word also carries the region count and the
// mapped byte total. A request walks the table one entry at a time (a memory
// read in S_SCAN_RD, then the compare in S_SCAN_EV); an insert or a split
// then shifts the upper entries up one at a time, each with a read and a
// write. An unmap without a split makes two passes over the table: one that
// looks for a split, then one that trims, drops and compacts the entries.
// Input stall is held while a request is in flight; a finished result word
// sits in the output register until taken, while the next request may start.
`timescale 1ns / 1ps
`default_nettype none
module address_region_table
  import arat_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = MaxRegionsDef,
  parameter int unsigned CW          = $clog2(MAX_REGIONS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [31:0]   cfg_wdata_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [31:0]   start_addr_i,
  input  wire logic [32:0]   end_addr_i,
  input  wire logic [31:0]   region_flags_i,
  input  wire logic [31:0]   span_length_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [2:0]         status_o,
  output logic [31:0]        found_start_o,
  output logic [32:0]        found_end_o,
  output logic [31:0]        found_flags_o,
  output logic [CW-1:0]      region_count_o,
  output logic [32:0]        total_mapped_o
);

  localparam int unsigned AW = $clog2(MAX_REGIONS);

  logic [31:0]   search_base_q;
  logic          out_valid_q;
  logic          busy, done, out_free;
  result_t       res;
  logic [CW-1:0] used;
  logic [32:0]   total;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  // the output slot is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_base_q <= SearchBaseRst;
    end else if (cfg_we_i) begin
      search_base_q <= cfg_wdata_i;
    end
  end

  // output register: load on completion, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      status_o       <= res.status;
      found_start_o  <= res.found_start;
      found_end_o    <= res.found_end;
      found_flags_o  <= res.found_flags;
      region_count_o <= used;
      total_mapped_o <= total;
    end
  end

  assign out_valid_o = out_valid_q;

  arat_ctrl #(
    .MAX_REGIONS(MAX_REGIONS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_valid_i && !busy),
    .busy_o        (busy),
    .req_type_i    (req_type_i),
    .start_addr_i  (start_addr_i),
    .end_addr_i    (end_addr_i),
    .region_flags_i(region_flags_i),
    .span_length_i (span_length_i),
    .search_base_i (search_base_q),
    .done_o        (done),
    .out_free_i    (out_free),
    .res_o         (res),
    .used_o        (used),
    .total_o       (total),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  arat_mem #(
    .DEPTH(MAX_REGIONS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
`default_nettype wire

@@ src/arat_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
module arat_mem
  import arat_pkg::*;
#(
  parameter int unsigned DEPTH = MaxRegionsDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/arat_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module arat_ctrl
  import arat_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = MaxRegionsDef,
  parameter int unsigned AW          = $clog2(MAX_REGIONS),
  parameter int unsigned CW          = $clog2(MAX_REGIONS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [31:0]   start_addr_i,
  input  wire logic [32:0]   end_addr_i,
  input  wire logic [31:0]   region_flags_i,
  input  wire logic [31:0]   span_length_i,
  input  wire logic [31:0]   search_base_i,
  output logic               done_o,
  input  wire logic          out_free_i,
  output result_t            res_o,
  output logic [CW-1:0]      used_o,
  output logic [32:0]        total_o,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output entry_t             mem_wdata_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  wire entry_t        mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_SPLIT_WR, S_DONE
  } state_e;

  localparam logic [CW-1:0] MaxCnt = CW'(MAX_REGIONS);
  localparam logic [CW-1:0] OneCnt = CW'(1);

  state_e        state_q;
  logic [1:0]    op_q;
  logic          pass_q;
  logic [31:0]   a_q;
  logic [32:0]   e_q;
  logic [31:0]   fl_q;
  logic [32:0]   size_q;
  logic [32:0]   cand_q;
  logic [32:0]   prev_hi_q;
  logic          prev_v_q;
  logic [CW-1:0] i_q, j_q, w_q, p_q, used_q;
  logic [32:0]   total_q;
  entry_t        kent_q;
  result_t       res_q;

  logic [32:0] size_in, st_in, en_in, lo, hi, a33;
  logic [33:0] cand_end;
  logic        ov, inside_rng;
  entry_t      trim;

  assign size_in  = ({1'b0, span_length_i} + PageMask) & ~PageMask;
  assign st_in    = {1'b0, start_addr_i[31:12], 12'h000};
  assign en_in    = st_in + size_in;
  assign lo       = {1'b0, mem_rdata_i.start_page, 12'h000};
  assign hi       = {mem_rdata_i.end_page, 12'h000};
  assign a33      = {1'b0, a_q};
  assign cand_end = {1'b0, cand_q} + {1'b0, size_q};
  assign ov         = !(hi <= a33 || lo >= e_q);
  assign inside_rng = (lo >= a33) && (hi <= e_q);

  // trimmed copy of the entry under scan for the compaction pass
  always_comb begin
    trim = mem_rdata_i;
    if (ov && lo < a33) begin
      trim.end_page = {1'b0, a_q[31:12]};
    end else if (ov) begin
      trim.start_page = e_q[31:12];
    end
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = p_q[AW-1:0];
    mem_wdata_o = trim;
    mem_raddr_o = i_q[AW-1:0];
    case (state_q)
      S_SCAN_EV: begin
        mem_we_o    = (op_q == REQ_UNMAP) && pass_q && !(ov && inside_rng);
        mem_waddr_o = w_q[AW-1:0];
      end
      S_SHIFT_RD: mem_raddr_o = AW'(j_q - OneCnt);
      S_SHIFT_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = j_q[AW-1:0];
        mem_wdata_o = mem_rdata_i;
      end
      S_PUT: begin
        mem_we_o = 1'b1;
        if (op_q == REQ_INSERT) begin
          mem_wdata_o = '{start_page: a_q[31:12], end_page: e_q[32:12], flags: fl_q};
        end else begin
          mem_wdata_o = '{start_page: e_q[31:12], end_page: kent_q.end_page,
                          flags: kent_q.flags};
        end
      end
      S_SPLIT_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(p_q - OneCnt);
        mem_wdata_o = '{start_page: kent_q.start_page, end_page: {1'b0, a_q[31:12]},
                        flags: kent_q.flags};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      total_q   <= '0;
      op_q      <= REQ_INSERT;
      pass_q    <= 1'b0;
      prev_v_q  <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      w_q       <= '0;
      p_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q     <= req_type_i;
            e_q      <= end_addr_i;
            fl_q     <= region_flags_i;
            size_q   <= size_in;
            cand_q   <= {1'b0, search_base_i};
            a_q      <= start_addr_i;
            i_q      <= '0;
            w_q      <= '0;
            pass_q   <= 1'b0;
            prev_v_q <= 1'b0;
            res_q    <= '{status: ST_OK, found_start: '0, found_end: '0, found_flags: '0};
            state_q  <= S_SCAN_RD;
            case (req_type_i)
              REQ_INSERT: begin
                if (start_addr_i[11:0] != 12'h000 || end_addr_i[11:0] != 12'h000 ||
                    {1'b0, start_addr_i} >= end_addr_i || end_addr_i > TopAddr) begin
                  res_q.status <= ST_INVALID;
                  state_q      <= S_DONE;
                end else if (used_q >= MaxCnt) begin
                  res_q.status <= ST_FULL;
                  state_q      <= S_DONE;
                end
              end
              REQ_LOOKUP: res_q.status <= ST_NOTFOUND;
              REQ_GAP: begin
                if (size_in == '0) begin
                  res_q.status <= ST_NOTFOUND;
                  state_q      <= S_DONE;
                end
              end
              default: begin
                a_q <= st_in[31:0];
                e_q <= en_in;
                if (size_in == '0 || en_in > TopAddr) begin
                  res_q.status <= ST_INVALID;
                  state_q      <= S_DONE;
                end
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          if (i_q == used_q) begin
            // end of table reached
            case (op_q)
              REQ_INSERT: begin
                if (prev_v_q && prev_hi_q > a33) begin
                  res_q.status <= ST_OVERLAP;
                  state_q      <= S_DONE;
                end else begin
                  p_q     <= used_q;
                  j_q     <= used_q;
                  state_q <= S_PUT;
                end
              end
              REQ_GAP: begin
                if (cand_end <= GapLimit) begin
                  res_q.found_start <= cand_q[31:0];
                  res_q.found_end   <= cand_end[32:0];
                end else begin
                  res_q.status <= ST_NOTFOUND;
                end
                state_q <= S_DONE;
              end
              REQ_UNMAP: begin
                if (!pass_q) begin
                  pass_q <= 1'b1;
                  i_q    <= '0;
                end else begin
                  used_q  <= w_q;
                  state_q <= S_DONE;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end else begin
            state_q <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          state_q <= S_SCAN_RD;
          i_q     <= i_q + OneCnt;
          case (op_q)
            REQ_INSERT: begin
              if (lo < a33) begin
                prev_hi_q <= hi;
                prev_v_q  <= 1'b1;
              end else if ((prev_v_q && prev_hi_q > a33) || e_q > lo) begin
                res_q.status <= ST_OVERLAP;
                state_q      <= S_DONE;
              end else begin
                p_q     <= i_q;
                j_q     <= used_q;
                state_q <= S_SHIFT_RD;
              end
            end
            REQ_LOOKUP: begin
              if (a33 >= lo && a33 < hi) begin
                res_q <= '{status: ST_OK, found_start: lo[31:0], found_end: hi,
                           found_flags: mem_rdata_i.flags};
                state_q <= S_DONE;
              end
            end
            REQ_GAP: begin
              if (hi > cand_q) begin
                if (cand_end <= {1'b0, lo}) begin
                  // gap found before this region
                  if (cand_end <= GapLimit) begin
                    res_q.found_start <= cand_q[31:0];
                    res_q.found_end   <= cand_end[32:0];
                  end else begin
                    res_q.status <= ST_NOTFOUND;
                  end
                  state_q <= S_DONE;
                end else begin
                  cand_q <= hi;
                end
              end
            end
            default: begin
              if (!pass_q) begin
                if (lo < a33 && hi > e_q) begin
                  if (used_q >= MaxCnt) begin
                    res_q.status <= ST_FULL;
                    state_q      <= S_DONE;
                  end else begin
                    kent_q  <= mem_rdata_i;
                    p_q     <= i_q + OneCnt;
                    j_q     <= used_q;
                    state_q <= S_SHIFT_RD;
                  end
                end
              end else begin
                if (ov && inside_rng) begin
                  total_q <= total_q - (hi - lo);
                end else begin
                  w_q <= w_q + OneCnt;
                  if (ov && lo < a33) begin
                    total_q <= total_q - (hi - a33);
                  end else if (ov) begin
                    total_q <= total_q - (e_q - lo);
                  end
                end
              end
            end
          endcase
        end
        S_SHIFT_RD: begin
          if (j_q == p_q) begin
            state_q <= S_PUT;
          end else begin
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          j_q     <= j_q - OneCnt;
          state_q <= S_SHIFT_RD;
        end
        S_PUT: begin
          used_q <= used_q + OneCnt;
          if (op_q == REQ_INSERT) begin
            total_q <= total_q + (e_q - a33);
            res_q   <= '{status: ST_OK, found_start: a_q, found_end: e_q, found_flags: fl_q};
            state_q <= S_DONE;
          end else begin
            total_q <= total_q - (e_q - a33);
            state_q <= S_SPLIT_WR;
          end
        end
        S_SPLIT_WR: state_q <= S_DONE;
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign done_o  = (state_q == S_DONE);
  assign res_o   = res_q;
  assign used_o  = used_q;
  assign total_o = total_q;

endmodule
`default_nettype wire

@@ src/arat_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module arat_chk
  import arat_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = MaxRegionsDef,
  parameter int unsigned CW          = $clog2(MAX_REGIONS + 1)
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire logic [2:0]    status_o,
  input wire logic [31:0]   found_start_o,
  input wire logic [32:0]   found_end_o,
  input wire logic [CW-1:0] region_count_o
);

  // a request occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous request in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> region_count_o <= CW'(MAX_REGIONS))
    else $error("region count beyond table size");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK && found_end_o != '0)
      |-> found_end_o > {1'b0, found_start_o})
    else $error("reported span empty or reversed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
      && $stable(found_start_o)))
    else $error("stalled result word changed");

endmodule

bind address_region_table arat_chk #(.MAX_REGIONS(MAX_REGIONS), .CW(CW)) u_arat_chk (.*);
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import arat_pkg::*;

  localparam int unsigned Slots = MaxRegionsDef;

  // One request word as the sender offers it.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [32:0] stop;
    logic [31:0] flags;
    logic [31:0] span;
  } req_word_t;

  // One result word, as predicted or as seen on the output port.
  typedef struct {
    logic [2:0]  status;
    logic [31:0] fstart;
    logic [32:0] fend;
    logic [31:0] fflags;
    logic [6:0]  count;
    logic [32:0] total;
  } res_word_t;

  // Region table shadow: computes the expected result of every accepted word
  // and holds those results until the output port delivers them.
  class region_table_shadow;
    logic [19:0] spage[Slots + 1];
    logic [20:0] epage[Slots + 1];
    logic [31:0] flg[Slots + 1];
    int unsigned used;
    logic [32:0] mapped;
    logic [31:0] base;
    res_word_t   pending[$];
    int unsigned errors;

    function new();
      used = 0;
      mapped = '0;
      base = SearchBaseRst;
      errors = 0;
    endfunction

    function logic [33:0] lo(int unsigned i);
      return {2'b0, spage[i], 12'h0};
    endfunction

    function logic [33:0] hi(int unsigned i);
      return {1'b0, epage[i], 12'h0};
    endfunction

    function void shift_up(int unsigned from);
      for (int unsigned i = used; i > from; i--) begin
        spage[i] = spage[i-1];
        epage[i] = epage[i-1];
        flg[i]   = flg[i-1];
      end
    endfunction

    // Note an accepted request word: update the shadow and queue its result.
    function void note_request(req_word_t q);
      res_word_t   r;
      logic [33:0] a, e, size, cand, st, en, s, t;
      int unsigned p, k, w;
      bit          split;
      r = '{default: '0};
      a = {2'b0, q.addr};
      e = {1'b0, q.stop};
      size = ({2'b0, q.span} + 34'hFFF) & ~34'hFFF;
      case (q.kind)
        REQ_INSERT: begin
          if (a[11:0] != 0 || e[11:0] != 0 || a >= e || e > {1'b0, TopAddr}) begin
            r.status = ST_INVALID;
          end else if (used >= Slots) begin
            r.status = ST_FULL;
          end else begin
            p = 0;
            while (p < used && lo(p) < a) p++;
            if ((p > 0 && hi(p-1) > a) || (p < used && e > lo(p))) begin
              r.status = ST_OVERLAP;
            end else begin
              shift_up(p);
              spage[p] = a[31:12];
              epage[p] = e[32:12];
              flg[p]   = q.flags;
              used++;
              mapped += e[32:0] - a[32:0];
              r.fstart = a[31:0];
              r.fend   = e[32:0];
              r.fflags = q.flags;
            end
          end
        end
        REQ_LOOKUP: begin
          r.status = ST_NOTFOUND;
          for (int unsigned i = 0; i < used; i++) begin
            if (a >= lo(i) && a < hi(i)) begin
              s = lo(i);
              t = hi(i);
              r.status = ST_OK;
              r.fstart = s[31:0];
              r.fend   = t[32:0];
              r.fflags = flg[i];
              break;
            end
          end
        end
        REQ_GAP: begin
          cand = {2'b0, base};
          if (size == 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (int unsigned i = 0; i < used; i++) begin
              if (hi(i) <= cand) continue;
              if (cand + size <= lo(i)) break;
              cand = hi(i);
            end
            if (cand + size <= GapLimit) begin
              r.fstart = cand[31:0];
              r.fend   = cand[32:0] + size[32:0];
            end else begin
              r.status = ST_NOTFOUND;
            end
          end
        end
        default: begin
          st = a & ~34'hFFF;
          en = st + size;
          if (size == 0 || en > {1'b0, TopAddr}) begin
            r.status = ST_INVALID;
          end else begin
            split = 0;
            k = 0;
            for (int unsigned i = 0; i < used; i++) begin
              if (lo(i) < st && hi(i) > en) begin
                split = 1;
                k = i;
                break;
              end
            end
            if (split) begin
              if (used >= Slots) begin
                r.status = ST_FULL;
              end else begin
                shift_up(k + 1);
                spage[k+1] = en[31:12];
                epage[k+1] = epage[k];
                flg[k+1]   = flg[k];
                epage[k]   = st[32:12];
                used++;
                mapped -= en[32:0] - st[32:0];
              end
            end else begin
              w = 0;
              for (int unsigned i = 0; i < used; i++) begin
                s = lo(i);
                t = hi(i);
                if (!(t <= st || s >= en)) begin
                  if (s >= st && t <= en) begin
                    mapped -= t[32:0] - s[32:0];
                    continue;
                  end else if (s < st) begin
                    mapped -= t[32:0] - st[32:0];
                    t = st;
                  end else begin
                    mapped -= en[32:0] - s[32:0];
                    s = en;
                  end
                end
                spage[w] = s[31:12];
                epage[w] = t[32:12];
                flg[w]   = flg[i];
                w++;
              end
              used = w;
            end
          end
        end
      endcase
      r.count = used[6:0];
      r.total = mapped;
      pending.push_back(r);
    endfunction

    function void flag(string what, logic [32:0] exp_v, logic [32:0] got_v);
      errors++;
      if (errors <= 10)
        $display("%t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
    endfunction

    // Check one delivered result word against the oldest expectation.
    function void check_result(res_word_t got);
      res_word_t x;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%t: result word with nothing expected", $realtime);
        return;
      end
      x = pending.pop_front();
      if (got.status !== x.status) flag("status", x.status, got.status);
      if (got.fstart !== x.fstart) flag("found_start", x.fstart, got.fstart);
      if (got.fend !== x.fend) flag("found_end", x.fend, got.fend);
      if (got.fflags !== x.fflags) flag("found_flags", x.fflags, got.fflags);
      if (got.count !== x.count) flag("region_count", x.count, got.count);
      if (got.total !== x.total) flag("total_mapped", x.total, got.total);
    endfunction

    function bit idle();
      return pending.size() == 0;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [31:0] start_addr_i;
  logic [32:0] end_addr_i;
  logic [31:0] region_flags_i;
  logic [31:0] span_length_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [31:0] found_start_o;
  logic [32:0] found_end_o;
  logic [31:0] found_flags_o;
  logic [6:0]  region_count_o;
  logic [32:0] total_mapped_o;

  region_table_shadow shadow;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;

  address_region_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .start_addr_i   (start_addr_i),
    .end_addr_i     (end_addr_i),
    .region_flags_i (region_flags_i),
    .span_length_i  (span_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_start_o  (found_start_o),
    .found_end_o    (found_end_o),
    .found_flags_o  (found_flags_o),
    .region_count_o (region_count_o),
    .total_mapped_o (total_mapped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: stall at random, or for a long stretch when asked, so that the
  // output register fills and the block backs up onto its input.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Take result words at the rising edge and hand them to the shadow.
  always @(posedge clk_i) begin
    res_word_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_o;
      got.fstart = found_start_o;
      got.fend   = found_end_o;
      got.fflags = found_flags_o;
      got.count  = region_count_o;
      got.total  = total_mapped_o;
      shadow.check_result(got);
    end
  end

  // Offer one request word; called and returning at a falling edge.
  task automatic send_word(req_word_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= q.kind;
    start_addr_i   <= q.addr;
    end_addr_i     <= q.stop;
    region_flags_i <= q.flags;
    span_length_i  <= q.span;
    do @(posedge clk_i); while (in_stall_o);
    shadow.note_request(q);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [1:0] kind, logic [31:0] addr, logic [32:0] stop,
                             logic [31:0] flags, logic [31:0] span);
    req_word_t q;
    q = '{kind, addr, stop, flags, span};
    send_word(q);
  endtask

  // Hold the sender until every expected word is back, then let the block
  // settle for its worst latency.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (!shadow.idle()) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_base(logic [31:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    shadow.base = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed requests clustered in a few windows so that they
  // collide, plus noise with every field fully random.
  task automatic random_word();
    req_word_t   q;
    logic [32:0] a;
    int unsigned r, npg;
    logic [31:0] wins[4];
    wins = '{32'h0000_0000, 32'h3000_0000, 32'hBFF0_0000, 32'hFFF0_0000};
    a   = {1'b0, wins[$urandom_range(3)]} + ({21'b0, 12'($urandom_range(255))} << 12);
    npg = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
    q   = '{REQ_INSERT, a[31:0], a + (npg << 12), $urandom, 32'(npg << 12)};
    r   = $urandom_range(99);
    if (r < 8) begin
      q = '{2'($urandom), $urandom, {1'($urandom), 32'($urandom)}, $urandom, $urandom};
    end else if (r < 48) begin
      if ($urandom_range(19) == 0) q.stop += $urandom_range(1, 4095);
    end else if (r < 65) begin
      q.kind = REQ_LOOKUP;
      q.addr[11:0] = 12'($urandom);
    end else if (r < 78) begin
      q.kind = REQ_GAP;
      q.span -= $urandom_range(4095);
    end else begin
      q.kind = REQ_UNMAP;
      q.addr[11:0] = 12'($urandom);
      q.span -= $urandom_range(4095);
    end
    send_word(q);
  endtask

  task automatic random_run(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      random_word();
      if (i % 100 == 99) drain();
    end
  endtask

  initial begin
    shadow = new();
    send_idle_pct = 30;
    recv_idle_pct = 61;
    hold_req = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    req_type_i = REQ_LOOKUP;
    start_addr_i = '0;
    end_addr_i = '0;
    region_flags_i = '0;
    span_length_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, bad ranges, overlap, split, trim, removal.
    send_fields(REQ_LOOKUP, 32'h0, 33'h0, 32'h0, 32'h0);
    send_fields(REQ_GAP, 32'h0, 33'h0, 32'h0, 32'h1);
    send_fields(REQ_INSERT, 32'h0, 33'h1000, 32'hFFFF_FFFF, 32'h0);
    send_fields(REQ_INSERT, 32'h0000_2001, 33'h3000, 32'h0, 32'h0);
    send_fields(REQ_INSERT, 32'h0000_2000, 33'h3001, 32'h0, 32'h0);
    send_fields(REQ_INSERT, 32'h0000_5000, 33'h5000, 32'h0, 32'h0);
    send_fields(REQ_INSERT, 32'hFFFF_F000, 33'h1_0000_1000, 32'h0, 32'h0);
    send_fields(REQ_INSERT, 32'hFFFF_F000, 33'h1_0000_0000, 32'h5A5A_A5A5, 32'h0);
    send_fields(REQ_INSERT, 32'h3000_0000, 33'h3001_0000, 32'h0000_0007, 32'h0);
    send_fields(REQ_INSERT, 32'h3000_F000, 33'h3002_0000, 32'h1, 32'h0);
    send_fields(REQ_LOOKUP, 32'hFFFF_FFFF, 33'h0, 32'h0, 32'h0);
    send_fields(REQ_LOOKUP, 32'h3000_8ABC, 33'h0, 32'h0, 32'h0);
    send_fields(REQ_LOOKUP, 32'h3001_0000, 33'h0, 32'h0, 32'h0);
    send_fields(REQ_GAP, 32'h0, 33'h0, 32'h0, 32'h0);
    send_fields(REQ_GAP, 32'h0, 33'h0, 32'h0, 32'h0000_0001);
    send_fields(REQ_GAP, 32'h0, 33'h0, 32'h0, 32'hFFFF_FFFF);
    send_fields(REQ_UNMAP, 32'h3000_0000, 33'h0, 32'h0, 32'h0);
    send_fields(REQ_UNMAP, 32'hFFFF_F000, 33'h0, 32'h0, 32'h0000_2000);
    send_fields(REQ_UNMAP, 32'h7000_0000, 33'h0, 32'h0, 32'h1000);
    send_fields(REQ_UNMAP, 32'h3000_4123, 33'h0, 32'h0, 32'h1000);
    send_fields(REQ_UNMAP, 32'h3000_E000, 33'h0, 32'h0, 32'h4000);
    send_fields(REQ_UNMAP, 32'hFFFF_F000, 33'h0, 32'h0, 32'h1000);
    send_fields(REQ_GAP, 32'h0, 33'h0, 32'h0, 32'h0000_5000);

    write_base(32'h0000_0000);
    random_run(250);
    write_base(32'hFFFF_FFFF);
    random_run(60);

    // Swap the idle weights and back the block up behind a long stall.
    write_base(32'h3000_0800);
    send_idle_pct = 61;
    recv_idle_pct = 30;
    @(posedge clk_i);
    hold_req = 1;
    @(negedge clk_i);
    random_run(250);

    write_base(32'hBFFF_F000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Fill the table with three-page regions, try a split while full, then
    // clear the whole block in one unmap.
    for (int unsigned k = 0; k < 70; k++)
      send_fields(REQ_INSERT, 32'h8000_0000 + (k << 14),
                  33'h8000_3000 + (k << 14), $urandom, 32'h0);
    send_fields(REQ_UNMAP, 32'h8000_1000, 33'h0, 32'h0, 32'h1000);
    send_fields(REQ_UNMAP, 32'h8000_0000, 33'h0, 32'h0, 32'h0011_8000);
    random_run(150);

    drain();
    if (shadow.errors == 0 && shadow.idle()) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
